### rtl/bellman_ford_shortest_paths_assert.svh
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication
`define BFSP_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bfsp_pkg.sv
package bfsp_pkg;

	localparam int DEF_MAX_VERTICES = 16;
	localparam int DEF_WEIGHT_BITS  = 16;

	localparam int DIST_BITS = 20;
	localparam int DIST_MAX  = 524287;
	localparam int DIST_MIN  = -524288;

	localparam logic [4:0] VCOUNT_RESET = 5'd16;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_RUN  = 1'b1
	} req_kind_t;

endpackage

### rtl/bfsp_wmem.sv
module bfsp_wmem import bfsp_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS,
	localparam int AW = 2 * $clog2(MAX_VERTICES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  logic [WEIGHT_BITS-1:0] wr_data,
	input  logic [AW-1:0]          rd_addr,
	output logic [WEIGHT_BITS-1:0] rd_data,
	output logic                   clear_busy
);

	localparam int DEPTH = 1 << AW;

	logic [WEIGHT_BITS-1:0] mem_q [DEPTH];
	logic [WEIGHT_BITS-1:0] rd_data_q;
	logic [AW-1:0]          clr_addr_q;
	logic                   clear_busy_q;

	// sweep zeros through every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			clear_busy_q <= 1'b1;
		end else if (clear_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clear_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = clear_busy_q;

endmodule

### rtl/bellman_ford_shortest_paths.sv
// Single-source shortest paths by Bellman-Ford over a weight matrix held in a
// synchronous memory (zero weight = no edge). A load item writes one entry. A
// run item relaxes edges one pair at a time through the weight memory and a
// distance memory, each with one read port, relaxing no edge out of a row
// whose vertex is not yet reachable; for n vertices in use it runs n-1 passes
// and then one check pass, the check stopping at the first edge that can still
// relax. Results then leave one per vertex, each held while out_stall is high,
// with last on the final one; no new item is taken until the final result
// leaves. After reset the weight memory is swept to zero, one entry a cycle,
// over all 2^(2*ceil(log2(MAX_VERTICES))) entries (256 at the default size);
// in_stall stays high meanwhile, and vertex_count may be written at any time
// the block is idle.
`include "bellman_ford_shortest_paths_assert.svh"

module bellman_ford_shortest_paths import bfsp_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [3:0]         from_vertex,
	input  logic [3:0]         to_vertex,
	input  logic signed [15:0] edge_weight,
	input  logic [3:0]         source_vertex,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         vertex_index,
	output logic signed [19:0] distance,
	output logic               reachable,
	output logic [3:0]         predecessor,
	output logic               has_predecessor,
	output logic               no_negative_cycle,
	output logic               last
);

	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int AW   = 2 * IW;
	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam int SUMW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
	localparam int DEW  = DIST_BITS + IW;

	localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'(DIST_MAX);
	localparam logic signed [SUMW-1:0] SUM_MIN = SUMW'(DIST_MIN);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ROW,
		S_ROWD,
		S_RD,
		S_EX,
		S_ORD,
		S_OLD,
		S_OWAIT
	} state_t;

	state_t state_q;

	logic [4:0]              vertex_count_q;
	logic [IW-1:0]           nm1_q;
	logic [IW-1:0]           p_q;
	logic [IW-1:0]           j_q;
	logic [IW-1:0]           k_q;
	logic [IW-1:0]           i_q;
	logic                    chk_q;
	logic                    ok_q;
	logic [MAX_VERTICES-1:0] reach_q;
	logic [MAX_VERTICES-1:0] pv_q;
	logic signed [DIST_BITS-1:0] dj_q;

	logic [DEW-1:0] dmem_q [MAX_VERTICES];
	logic [DEW-1:0] drd_q;

	logic               out_valid_q;
	logic [3:0]         vertex_index_q;
	logic signed [19:0] distance_q;
	logic               reachable_q;
	logic [3:0]         predecessor_q;
	logic               has_predecessor_q;
	logic               no_negative_cycle_q;
	logic               last_q;

	// weight memory port signals
	logic                          wm_wr_en;
	logic [AW-1:0]                 wm_wr_addr;
	logic [WEIGHT_BITS-1:0]        wm_wr_data;
	logic [AW-1:0]                 wm_rd_addr;
	logic signed [WEIGHT_BITS-1:0] w_c;
	logic                          clear_busy;

	logic [CMPW-1:0]             vc_ext;
	logic [IW-1:0]               nm1_c;
	logic                        src_ok;
	logic                        load_ok;
	logic                        src_init;
	logic [IW-1:0]               draddr_c;
	logic                        dwr_en;
	logic signed [DIST_BITS-1:0] dk_c;
	logic signed [SUMW-1:0]      cand_c;
	logic signed [DIST_BITS-1:0] cand_sat_c;
	logic                        relax_c;
	logic                        row_last;
	logic                        pass_last;

	bfsp_wmem #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_wmem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wm_wr_en),
		.wr_addr   (wm_wr_addr),
		.wr_data   (wm_wr_data),
		.rd_addr   (wm_rd_addr),
		.rd_data   (w_c),
		.clear_busy(clear_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// vertices in use, less one
	assign vc_ext = CMPW'(vertex_count_q);
	always_comb begin
		if (vc_ext == '0) begin
			nm1_c = '0;
		end else if (vc_ext > CMPW'(MAX_VERTICES)) begin
			nm1_c = IW'(MAX_VERTICES - 1);
		end else begin
			nm1_c = IW'(vc_ext - 1'b1);
		end
	end

	assign src_ok  = CMPW'(source_vertex) <= CMPW'(nm1_c);
	assign load_ok = (CMPW'(from_vertex) < CMPW'(MAX_VERTICES)) &&
			(CMPW'(to_vertex) < CMPW'(MAX_VERTICES));

	assign in_stall   = (state_q != S_IDLE);
	assign wm_wr_en   = (state_q == S_IDLE) && in_valid && (req_type == REQ_LOAD) && load_ok;
	assign wm_wr_addr = {IW'(from_vertex), IW'(to_vertex)};
	assign wm_wr_data = WEIGHT_BITS'(edge_weight);
	assign wm_rd_addr = {j_q, k_q};
	assign src_init   = (state_q == S_IDLE) && in_valid && (req_type == REQ_RUN);

	always_comb begin
		case (state_q)
			S_ROW:   draddr_c = j_q;
			S_ORD:   draddr_c = i_q;
			default: draddr_c = k_q;
		endcase
	end

	// relaxation datapath
	assign dk_c   = drd_q[DIST_BITS-1:0];
	assign cand_c = SUMW'(dj_q) + SUMW'(w_c);
	always_comb begin
		if (cand_c > SUM_MAX) begin
			cand_sat_c = DIST_BITS'(SUM_MAX);
		end else if (cand_c < SUM_MIN) begin
			cand_sat_c = DIST_BITS'(SUM_MIN);
		end else begin
			cand_sat_c = DIST_BITS'(cand_c);
		end
	end
	assign relax_c = (j_q != k_q) && (w_c != '0) &&
			(!reach_q[k_q] || (cand_c < SUMW'(dk_c)));
	assign dwr_en    = (state_q == S_EX) && !chk_q && relax_c;
	assign row_last  = (j_q == nm1_q);
	assign pass_last = (p_q == nm1_q - 1'b1);

	// source distance starts at zero on every run
	always_ff @(posedge clk) begin
		if (dwr_en) begin
			dmem_q[k_q] <= {j_q, cand_sat_c};
		end else if (src_init) begin
			dmem_q[IW'(source_vertex)] <= '0;
		end
		drd_q <= dmem_q[draddr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= S_CLEAR;
			nm1_q               <= '0;
			p_q                 <= '0;
			j_q                 <= '0;
			k_q                 <= '0;
			i_q                 <= '0;
			chk_q               <= 1'b0;
			ok_q                <= 1'b1;
			reach_q             <= '0;
			pv_q                <= '0;
			out_valid_q         <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (!clear_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid && (req_type == REQ_RUN)) begin
						nm1_q   <= nm1_c;
						p_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						chk_q   <= (nm1_c == '0);
						ok_q    <= 1'b1;
						pv_q    <= '0;
						reach_q <= '0;
						if (src_ok) begin
							reach_q[IW'(source_vertex)] <= 1'b1;
						end
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					k_q <= '0;
					if (reach_q[j_q]) begin
						state_q <= S_ROWD;
					end else if (!row_last) begin
						j_q <= j_q + 1'b1;
					end else if (chk_q) begin
						i_q     <= '0;
						state_q <= S_ORD;
					end else begin
						j_q <= '0;
						if (pass_last) begin
							chk_q <= 1'b1;
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				S_ROWD: begin
					dj_q    <= drd_q[DIST_BITS-1:0];
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					if (chk_q && relax_c) begin
						ok_q    <= 1'b0;
						i_q     <= '0;
						state_q <= S_ORD;
					end else begin
						if (relax_c) begin
							reach_q[k_q] <= 1'b1;
							pv_q[k_q]    <= 1'b1;
						end
						if (k_q != nm1_q) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RD;
						end else if (!row_last) begin
							j_q     <= j_q + 1'b1;
							state_q <= S_ROW;
						end else if (chk_q) begin
							i_q     <= '0;
							state_q <= S_ORD;
						end else begin
							j_q     <= '0;
							state_q <= S_ROW;
							if (pass_last) begin
								chk_q <= 1'b1;
							end else begin
								p_q <= p_q + 1'b1;
							end
						end
					end
				end
				S_ORD: begin
					state_q <= S_OLD;
				end
				S_OLD: begin
					out_valid_q         <= 1'b1;
					vertex_index_q      <= 4'(i_q);
					reachable_q         <= reach_q[i_q];
					distance_q          <= reach_q[i_q] ? drd_q[DIST_BITS-1:0] : '0;
					has_predecessor_q   <= pv_q[i_q];
					predecessor_q       <= pv_q[i_q] ? 4'(drd_q[DEW-1:DIST_BITS]) : '0;
					no_negative_cycle_q <= ok_q;
					last_q              <= (i_q == nm1_q);
					state_q             <= S_OWAIT;
				end
				S_OWAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (i_q == nm1_q) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign vertex_index      = vertex_index_q;
	assign distance          = distance_q;
	assign reachable         = reachable_q;
	assign predecessor       = predecessor_q;
	assign has_predecessor   = has_predecessor_q;
	assign no_negative_cycle = no_negative_cycle_q;
	assign last              = last_q;

	`BFSP_ASSERT_HOLDS(a_unreach_clean, clk, arst_n, out_valid && !reachable, (distance == '0) && !has_predecessor, "unreachable vertex carries distance or predecessor")
	`BFSP_ASSERT_NEXT(a_last_frees_input, clk, arst_n, out_valid && !out_stall && last, !in_stall, "block not free after final result")
	`BFSP_ASSERT_HOLDS(a_clear_quiet, clk, arst_n, clear_busy, in_stall && !out_valid, "activity during weight memory sweep")

endmodule

### tb/tb_top.sv
module tb_top;
	import bfsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS  = 410;
	localparam int SETTLE_CYC   = 12;
	localparam int TAIL_CYC     = 60;
	localparam int HOLD_CYC     = 10000;
	localparam int QUIET_LIMIT  = 80000;
	localparam int REPORT_LIMIT = 50;

	typedef enum logic {
		STEP_ITEM,
		STEP_CFG
	} step_kind_t;

	typedef enum logic [1:0] {
		GL_NONE,
		GL_SOURCE_ONLY,
		GL_UNREACHED
	} glance_t;

	typedef struct {
		step_kind_t act;
		req_kind_t  kind;
		logic [3:0] fr;
		logic [3:0] to;
		logic [15:0] w;
		logic [3:0] src;
		logic [4:0] vc;
		glance_t    g;
	} step_t;

	typedef struct {
		logic [3:0]         idx;
		logic signed [19:0] dval;
		logic               reach;
		logic [3:0]         pred;
		logic               has_pred;
		logic               no_neg;
		logic               last;
	} vertex_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [4:0]         cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               req_type = 1'b0;
	logic [3:0]         from_vertex = '0;
	logic [3:0]         to_vertex = '0;
	logic signed [15:0] edge_weight = '0;
	logic [3:0]         source_vertex = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         vertex_index;
	logic signed [19:0] distance;
	logic               reachable;
	logic [3:0]         predecessor;
	logic               has_predecessor;
	logic               no_negative_cycle;
	logic               last;

	glance_t cur_glance = GL_NONE;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_trig = 0;
	int items_sent = 0;
	int err_cnt = 0;
	int quiet_cnt = 0;

	// graph as the block should hold it
	logic signed [15:0] wmat [16][16] = '{default: '{default: '0}};
	logic [4:0] vcount = VCOUNT_RESET;
	vertex_t path_q [$];

	step_t dir_tab [23] = '{
		// empty graph after reset
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd5,  5'd0,  GL_SOURCE_ONLY},
		// self loop, never relaxed
		'{STEP_ITEM, REQ_LOAD, 4'd15, 4'd15, 16'h8000, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_LOAD, 4'd0,  4'd1,  16'h7fff, 4'd15, 5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_LOAD, 4'd1,  4'd2,  16'h8000, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_LOAD, 4'd2,  4'd3,  16'h0001, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_LOAD, 4'd15, 4'd0,  16'h0005, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_LOAD, 4'd0,  4'd15, 16'hffff, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd15, 5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_RUN,  4'd15, 4'd15, 16'hffff, 4'd0,  5'd0,  GL_NONE},
		// negative cycle deep enough to saturate low
		'{STEP_ITEM, REQ_LOAD, 4'd3,  4'd4,  16'h8000, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_LOAD, 4'd4,  4'd3,  16'h8000, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  GL_NONE},
		// zero weight removes the edge
		'{STEP_ITEM, REQ_LOAD, 4'd4,  4'd3,  16'h0000, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd2,  5'd0,  GL_NONE},
		'{STEP_CFG,  REQ_LOAD, 4'd0,  4'd0,  16'h0000, 4'd0,  5'd4,  GL_NONE},
		// source beyond the vertex count
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd9,  5'd0,  GL_UNREACHED},
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd1,  5'd0,  GL_NONE},
		// zero count acts as one vertex
		'{STEP_CFG,  REQ_LOAD, 4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  GL_NONE},
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  GL_SOURCE_ONLY},
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd1,  5'd0,  GL_UNREACHED},
		// count above the built size clamps
		'{STEP_CFG,  REQ_LOAD, 4'd0,  4'd0,  16'h0000, 4'd0,  5'd31, GL_NONE},
		'{STEP_ITEM, REQ_RUN,  4'd0,  4'd0,  16'h0000, 4'd14, 5'd0,  GL_NONE},
		'{STEP_CFG,  REQ_LOAD, 4'd0,  4'd0,  16'h0000, 4'd0,  5'd16, GL_NONE}
	};

	bellman_ford_shortest_paths dut (.*);

	always #1 clk = ~clk;

	function automatic int used_n();
		return (vcount == 0) ? 1 : ((vcount > 16) ? 16 : int'(vcount));
	endfunction

	function automatic void solve_paths(logic [3:0] src);
		int n;
		longint dist_v [16];
		bit reach_v [16];
		logic [3:0] pred_v [16];
		bit pred_ok [16];
		bit clean;
		longint cand;
		vertex_t res;
		n = used_n();
		clean = 1'b1;
		for (int i = 0; i < 16; i++) begin
			dist_v[i] = 0;
			reach_v[i] = 1'b0;
			pred_v[i] = '0;
			pred_ok[i] = 1'b0;
		end
		if (src < n)
			reach_v[src] = 1'b1;
		for (int p = 0; p + 1 < n; p++)
			for (int j = 0; j < n; j++)
				for (int k = 0; k < n; k++)
					if (j != k && wmat[j][k] != 0 && reach_v[j]) begin
						cand = dist_v[j] + longint'(wmat[j][k]);
						if (!reach_v[k] || cand < dist_v[k]) begin
							dist_v[k] = (cand > DIST_MAX) ? DIST_MAX :
								((cand < DIST_MIN) ? DIST_MIN : cand);
							reach_v[k] = 1'b1;
							pred_v[k] = 4'(j);
							pred_ok[k] = 1'b1;
						end
					end
		for (int j = 0; j < n && clean; j++)
			for (int k = 0; k < n && clean; k++)
				if (j != k && wmat[j][k] != 0 && reach_v[j] && (!reach_v[k] ||
						dist_v[j] + longint'(wmat[j][k]) < dist_v[k]))
					clean = 1'b0;
		for (int i = 0; i < n; i++) begin
			res.idx = 4'(i);
			res.dval = reach_v[i] ? 20'(dist_v[i]) : '0;
			res.reach = reach_v[i];
			res.pred = pred_ok[i] ? pred_v[i] : '0;
			res.has_pred = pred_ok[i];
			res.no_neg = clean;
			res.last = (i == n - 1);
			path_q.push_back(res);
		end
	endfunction

	function automatic void note_mismatch(string field, longint exp_val, longint act_val);
		err_cnt++;
		if (err_cnt <= REPORT_LIMIT)
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
	endfunction

	// model update and result check
	always @(posedge clk) begin : monitor
		vertex_t want;
		int n;
		if (arst_n) begin
			if (cfg_we)
				vcount = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (path_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_LIMIT)
						$error("result for vertex %0d with none expected", vertex_index);
				end else begin
					want = path_q.pop_front();
					if (vertex_index !== want.idx)
						note_mismatch("vertex_index", want.idx, vertex_index);
					if (distance !== want.dval)
						note_mismatch("distance", want.dval, distance);
					if (reachable !== want.reach)
						note_mismatch("reachable", want.reach, reachable);
					if (predecessor !== want.pred)
						note_mismatch("predecessor", want.pred, predecessor);
					if (has_predecessor !== want.has_pred)
						note_mismatch("has_predecessor", want.has_pred, has_predecessor);
					if (no_negative_cycle !== want.no_neg)
						note_mismatch("no_negative_cycle", want.no_neg, no_negative_cycle);
					if (last !== want.last)
						note_mismatch("last", want.last, last);
				end
			end
			if (in_valid && !in_stall) begin
				if (req_type == REQ_LOAD) begin
					wmat[from_vertex][to_vertex] = edge_weight;
				end else if (cur_glance == GL_NONE) begin
					solve_paths(source_vertex);
				end else begin
					n = used_n();
					for (int i = 0; i < n; i++) begin
						want.idx = 4'(i);
						want.dval = '0;
						want.reach = (cur_glance == GL_SOURCE_ONLY) && (i == source_vertex);
						want.pred = '0;
						want.has_pred = 1'b0;
						want.no_neg = 1'b1;
						want.last = (i == n - 1);
						path_q.push_back(want);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cnt = 0;
			else
				quiet_cnt++;
		end
	end

	always @(posedge clk) begin
		if (quiet_cnt >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_trig != hold_seen) begin
				hold_seen = hold_trig;
				for (int c = 0; c < HOLD_CYC; c++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	task automatic send_item(req_kind_t kind, logic [3:0] fr, logic [3:0] to,
			logic [15:0] w, logic [3:0] src, glance_t g);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		from_vertex <= fr;
		to_vertex <= to;
		edge_weight <= w;
		source_vertex <= src;
		cur_glance <= g;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic write_vcount(logic [4:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (path_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [4:0] vc;
		logic [3:0] fr, to, src;
		logic [15:0] w;
		int n, len, pick;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[r]) begin
			if (dir_tab[r].act == STEP_CFG)
				write_vcount(dir_tab[r].vc);
			else
				send_item(dir_tab[r].kind, dir_tab[r].fr, dir_tab[r].to, dir_tab[r].w,
					dir_tab[r].src, dir_tab[r].g);
		end

		for (int b = 0; items_sent < TOTAL_ITEMS; b++) begin
			case (b % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct = 27;
					recv_stall_pct = 27;
				end
			endcase
			pick = $urandom_range(19, 0);
			if (pick == 0)
				vc = 5'd16;
			else if (pick == 1)
				vc = 5'($urandom_range(31, 17));
			else if (pick == 2)
				vc = 5'd0;
			else
				vc = 5'($urandom_range(6, 2));
			write_vcount(vc);
			n = (vc == 0) ? 1 : ((vc > 16) ? 16 : int'(vc));

			// run requests stall behind a long receiver hold-off
			if (b == 4) begin
				hold_trig++;
				repeat (4)
					send_item(REQ_RUN, 4'($urandom), 4'($urandom), 16'($urandom),
						4'($urandom_range(n - 1, 0)), GL_NONE);
			end

			len = $urandom_range(14, 4);
			for (int i = 0; i < len; i++) begin
				if (i == len - 1 || $urandom_range(3, 0) == 0) begin
					src = ($urandom_range(9, 0) == 0) ? 4'($urandom) :
						4'($urandom_range(n - 1, 0));
					send_item(REQ_RUN, 4'($urandom), 4'($urandom), 16'($urandom), src,
						GL_NONE);
				end else begin
					if ($urandom_range(6, 0) == 0) begin
						fr = 4'($urandom);
						to = 4'($urandom);
					end else begin
						fr = 4'($urandom_range(n - 1, 0));
						to = 4'($urandom_range(n - 1, 0));
					end
					pick = $urandom_range(19, 0);
					if (pick < 8)
						w = 16'($urandom_range(20, 1));
					else if (pick < 11)
						w = -16'($urandom_range(5, 1));
					else if (pick < 14)
						w = '0;
					else
						w = 16'($urandom);
					send_item(REQ_LOAD, fr, to, w, 4'($urandom), GL_NONE);
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (path_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYC) @(negedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
